[rtl/slbd_pkg.sv]
// ----------------------------------------------------------------------------
// slbd_pkg: shared types and constants for the status LED driver
// Request and result structs, register indexes, reset values and FSM states.
// ----------------------------------------------------------------------------
`default_nettype none

package slbd_pkg;

  localparam int unsigned NowW    = 32;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned StepW   = 8;
  localparam int unsigned LevelW  = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ERROR_PERIOD = 3'd0,
    CFG_RAMP_STEP    = 3'd1,
    CFG_ERROR_LEVEL  = 3'd2,
    CFG_CHARGE_LEVEL = 3'd3,
    CFG_READY_LEVEL  = 3'd4,
    CFG_READY_RING   = 3'd5,
    CFG_FIRE_RING    = 3'd6
  } cfg_idx_e;

  // Register reset values.
  localparam logic [PeriodW-1:0] ErrorPeriodRst = 16'd500;
  localparam logic [StepW-1:0]   RampStepRst    = 8'd12;
  localparam logic [LevelW-1:0]  ErrorLevelRst  = 7'd120;
  localparam logic [LevelW-1:0]  ChargeLevelRst = 7'd120;
  localparam logic [LevelW-1:0]  ReadyLevelRst  = 7'd90;
  localparam logic [LevelW-1:0]  ReadyRingRst   = 7'd50;
  localparam logic [LevelW-1:0]  FireRingRst    = 7'd120;

  typedef struct packed {
    logic [NowW-1:0] now_ms;
    logic            fire_enable;
    logic            firing_now;
    logic            charging;
    logic            interlock_closed;
    logic            fault;
    logic            critical_battery;
  } in_req_t;

  typedef struct packed {
    logic [LevelW-1:0] red_level;
    logic [LevelW-1:0] green_level;
    logic [LevelW-1:0] blue_level;
    logic [LevelW-1:0] ready_ring;
    logic [LevelW-1:0] fire_ring;
  } out_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

[rtl/slbd_div.sv]
// ----------------------------------------------------------------------------
// slbd_div: bit-serial restoring divider
// Divides a 32-bit elapsed time by an 8-bit step, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module slbd_div
  import slbd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NowW-1:0]  dividend_i,
  input  wire logic [StepW-1:0] divisor_i,
  output logic                  done_o,
  output logic [NowW-1:0]       quotient_o
);

  localparam int unsigned CntW = $clog2(NowW);

  logic [NowW-1:0]  num_q;
  logic [StepW-1:0] rem_q;
  logic [StepW-1:0] div_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [StepW:0]   trial;
  logic             fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem_q, num_q[NowW-1]};
  assign fits  = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(NowW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= {num_q[NowW-2:0], fits};
      rem_q <= fits ? StepW'(trial - {1'b0, div_q}) : trial[StepW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule

`default_nettype wire

[rtl/status_led_blink_breathe_driver.sv]
// ----------------------------------------------------------------------------
// status_led_blink_breathe_driver: status LED blink, breathe and steady levels
// Each request carries the millisecond clock and six status flags; the block
// answers with one result of five PWM levels (red, green, blue, ready ring
// and fire ring). A change in any flag restarts the timer mark. The main LED
// follows a priority chain: dark on critical battery while not charging
// with the interlock closed, red blinking at the error period while a fault
// is present, blue breathing as a triangle ramp while charging, steady blue
// with the interlock open, steady green when not armed, off when armed. The
// breathing ramp catches up by the elapsed time divided by the ramp step,
// saturated into the range from zero to the charge level. Each request
// passes through the states CALC (form the elapsed time and start the
// divider), DIVIDE (the bit-serial divider, one quotient bit a cycle, then
// its done signal) and FINISH (update state and load the output register).
// The input stalls for that whole time, so a new request is accepted only
// once the last one is through. A finished result waits in the output
// register until taken; meanwhile the next request is still accepted and
// worked on, and only its final step holds until the output register is
// free.
// Configuration registers are written through a plain write port and must
// only be changed while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module status_led_blink_breathe_driver
  import slbd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Request channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire in_req_t            in_req_i,
  // Result channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output out_res_t                out_res_o,
  // Configuration write port
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgDatW-1:0] cfg_wdata_i
);

  // Configuration registers.
  logic [PeriodW-1:0] error_period_q;
  logic [StepW-1:0]   ramp_step_q;
  logic [LevelW-1:0]  error_level_q;
  logic [LevelW-1:0]  charge_level_q;
  logic [LevelW-1:0]  ready_level_q;
  logic [LevelW-1:0]  ready_ring_q;
  logic [LevelW-1:0]  fire_ring_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_period_q <= ErrorPeriodRst;
      ramp_step_q    <= RampStepRst;
      error_level_q  <= ErrorLevelRst;
      charge_level_q <= ChargeLevelRst;
      ready_level_q  <= ReadyLevelRst;
      ready_ring_q   <= ReadyRingRst;
      fire_ring_q    <= FireRingRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ERROR_PERIOD: error_period_q <= cfg_wdata_i[PeriodW-1:0];
        CFG_RAMP_STEP:    ramp_step_q    <= cfg_wdata_i[StepW-1:0];
        CFG_ERROR_LEVEL:  error_level_q  <= cfg_wdata_i[LevelW-1:0];
        CFG_CHARGE_LEVEL: charge_level_q <= cfg_wdata_i[LevelW-1:0];
        CFG_READY_LEVEL:  ready_level_q  <= cfg_wdata_i[LevelW-1:0];
        CFG_READY_RING:   ready_ring_q   <= cfg_wdata_i[LevelW-1:0];
        CFG_FIRE_RING:    fire_ring_q    <= cfg_wdata_i[LevelW-1:0];
        default: ;  // Unused index: the write is dropped.
      endcase
    end
  end

  // Sequencer and persistent LED state.
  state_e            state_q, state_d;
  in_req_t           req_q;
  logic [5:0]        seen_q, seen_d;
  logic [NowW-1:0]   mark_q, mark_d;
  logic [LevelW-1:0] main_q, main_d;
  logic              down_q, down_d;
  logic [NowW-1:0]   diff_q;
  logic              behind_q;
  logic              out_valid_q, out_valid_d;
  out_res_t          out_res_q, out_res_d;

  logic              in_accept;
  logic [5:0]        in_flags;
  logic [NowW-1:0]   diff_now;
  logic              div_start;
  logic              div_done;
  logic [NowW-1:0]   div_quot;
  logic [StepW-1:0]  step_eff;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_flags = {in_req_i.critical_battery, in_req_i.fault, in_req_i.interlock_closed,
                     in_req_i.charging, in_req_i.firing_now, in_req_i.fire_enable};

  // A step interval of zero behaves as one millisecond.
  assign step_eff  = (ramp_step_q == '0) ? StepW'(1) : ramp_step_q;
  assign diff_now  = req_q.now_ms - mark_q;
  assign div_start = (state_q == ST_CALC);

  // The elapsed time is divided on every request; the quotient is only
  // used when the breathing ramp moves forward in time.
  slbd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (diff_now),
    .divisor_i  (step_eff),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Decision logic for the finishing cycle.
  logic              dark;
  logic              blink_due;
  logic              breathe_due;
  logic [StepW-1:0]  mag;
  logic [StepW-1:0]  lvl_raw;
  logic [LevelW-1:0] lvl_ramp;

  always_comb begin
    dark        = req_q.critical_battery && !req_q.charging && req_q.interlock_closed;
    blink_due   = (mark_q == '0) || behind_q || (diff_q > NowW'(error_period_q));
    breathe_due = behind_q || (diff_q > NowW'(step_eff));

    // When the clock is behind the mark the ramp moves by one level. Any
    // catch-up of 128 levels or more saturates at either end of the ramp.
    if (behind_q) begin
      mag = StepW'(1);
    end else if (|div_quot[NowW-1:LevelW]) begin
      mag = StepW'(1 << LevelW);
    end else begin
      mag = {1'b0, div_quot[LevelW-1:0]};
    end

    if (down_q) begin
      lvl_raw = (mag > {1'b0, main_q}) ? '0 : ({1'b0, main_q} - mag);
    end else begin
      lvl_raw = {1'b0, main_q} + mag;
    end
    lvl_ramp = (lvl_raw > {1'b0, charge_level_q}) ? charge_level_q : lvl_raw[LevelW-1:0];
  end

  always_comb begin
    state_d     = state_q;
    seen_d      = seen_q;
    mark_d      = mark_q;
    main_d      = main_q;
    down_d      = down_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          // Any change of the status flags restarts the timer mark.
          if (in_flags != seen_q) begin
            seen_d = in_flags;
            mark_d = '0;
          end
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_res_d   = '0;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;

          if (dark) begin
            // Main LED off; its state is left as it was.
          end else if (req_q.fault) begin
            if (blink_due) begin
              main_d = (main_q != '0) ? '0 : error_level_q;
              mark_d = req_q.now_ms;
            end
            out_res_d.red_level = main_d;
          end else if (req_q.charging) begin
            if (mark_q == '0) begin
              main_d = charge_level_q;
              down_d = 1'b1;
              mark_d = req_q.now_ms;
            end else if (breathe_due) begin
              main_d = lvl_ramp;
              // Reaching either end of the ramp turns it around.
              if (lvl_ramp == '0 || lvl_ramp == charge_level_q) begin
                down_d = !down_q;
              end
              mark_d = req_q.now_ms;
            end
            out_res_d.blue_level = main_d;
          end else if (!req_q.interlock_closed) begin
            main_d = charge_level_q;
            mark_d = '0;
            out_res_d.blue_level = charge_level_q;
          end else if (!req_q.fire_enable) begin
            main_d = ready_level_q;
            mark_d = '0;
            out_res_d.green_level = ready_level_q;
          end

          // Ring LEDs light only when armed and no fault is present.
          if (!req_q.fault && req_q.fire_enable) begin
            if (req_q.firing_now) begin
              out_res_d.fire_ring = fire_ring_q;
            end else if (req_q.interlock_closed) begin
              out_res_d.ready_ring = ready_ring_q;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seen_q      <= '0;
      mark_q      <= '0;
      main_q      <= '0;
      down_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seen_q      <= seen_d;
      mark_q      <= mark_d;
      main_q      <= main_d;
      down_q      <= down_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_req_i;
    end
    if (state_q == ST_CALC) begin
      diff_q   <= diff_now;
      behind_q <= (mark_q > req_q.now_ms);
    end
    out_res_q <= out_res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the status LED blink and breathe driver
// Drives millisecond tick requests with random idling on both channels,
// predicts the five PWM levels of every accepted request in a behavioral
// model, and compares each result field by field in order of arrival.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
  import slbd_pkg::*;
();

  // Status flag bits in the order the block keeps its copy of them.
  localparam logic [5:0] FlagEn   = 6'd1;
  localparam logic [5:0] FlagFire = 6'd2;
  localparam logic [5:0] FlagChg  = 6'd4;
  localparam logic [5:0] FlagIlk  = 6'd8;
  localparam logic [5:0] FlagFlt  = 6'd16;
  localparam logic [5:0] FlagBat  = 6'd32;

  // Register index with no register behind it; a write there must be ignored.
  localparam logic [CfgIdxW-1:0] CfgUnusedIdx = 3'd7;

  localparam int unsigned NumPhases     = 8;
  localparam int unsigned ItemsPerPhase = 100;
  localparam int unsigned IdlePct       = 36;

  // One row of the directed table. When chk is set, res holds the levels
  // that can be read straight off the priority chain; otherwise the
  // predictor supplies them.
  typedef struct {
    in_req_t  rq;
    bit       chk;
    out_res_t res;
  } dir_row_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_req_t              in_req_i    = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_res_t             out_res_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i   = '0;
  logic [CfgDatW-1:0]   cfg_wdata_i = '0;

  // While calm is set neither side idles, giving a long back-to-back stretch.
  logic calm = 1'b0;

  // Levels predicted for accepted requests, oldest first.
  out_res_t    expected_levels_q[$];
  int unsigned mismatch_cnt = 0;

  // Predictor copy of the configuration registers.
  logic [15:0] err_period;
  logic [7:0]  ramp_step;
  logic [6:0]  err_level;
  logic [6:0]  chg_level;
  logic [6:0]  rdy_level;
  logic [6:0]  rdy_ring_level;
  logic [6:0]  fire_ring_level;

  // Predictor copy of the block state.
  logic [5:0]  flag_copy;
  logic [31:0] mark;
  logic [6:0]  main_lvl;
  logic [6:0]  ring_lvl;
  logic        ramp_dn;

  status_led_blink_breathe_driver dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // Works out the levels for one tick request and advances the predictor
  // state exactly as the block is meant to.
  function automatic out_res_t predict_levels(in_req_t rq);
    out_res_t    res;
    logic [5:0]  flags;
    logic [31:0] now;
    logic [31:0] step;
    longint      mag;
    longint      lvl;
    longint      top;
    res   = '0;
    now   = rq.now_ms;
    flags = {rq.critical_battery, rq.fault, rq.interlock_closed,
             rq.charging, rq.firing_now, rq.fire_enable};
    // Any flag change restarts the timer, just as the block does.
    if (flags != flag_copy) begin
      flag_copy = flags;
      mark      = '0;
    end

    if (rq.critical_battery && !rq.charging && rq.interlock_closed) begin
      // Dark: main level, mark and ramp direction are all left alone.
    end else if (rq.fault) begin
      // A zero mark is unset, and a current time behind the mark forces a toggle.
      if (mark == 0 || mark > now || (now - mark) > err_period) begin
        main_lvl = (main_lvl != 0) ? 7'd0 : err_level;
        mark     = now;
      end
      res.red_level = main_lvl;
    end else if (rq.charging) begin
      step = (ramp_step == 0) ? 32'd1 : {24'd0, ramp_step};
      if (mark == 0) begin
        main_lvl = chg_level;
        ramp_dn  = 1'b1;
        mark     = now;
      end else if (mark > now || (now - mark) > step) begin
        // Catch up by whole steps; a current time behind the mark moves one level.
        mag = 1;
        if (mark < now) mag = longint'((now - mark) / step);
        lvl = longint'(main_lvl);
        lvl = ramp_dn ? lvl - mag : lvl + mag;
        top = longint'(chg_level);
        if (lvl < 0) lvl = 0;
        if (lvl > top) lvl = top;
        main_lvl = lvl[6:0];
        if (main_lvl == 0 || main_lvl == chg_level) ramp_dn = !ramp_dn;
        mark = now;
      end
      res.blue_level = main_lvl;
    end else if (!rq.interlock_closed) begin
      main_lvl       = chg_level;
      mark           = '0;
      res.blue_level = main_lvl;
    end else if (!rq.fire_enable) begin
      main_lvl        = rdy_level;
      mark            = '0;
      res.green_level = main_lvl;
    end

    if (!rq.fault && rq.fire_enable) begin
      if (rq.firing_now) begin
        ring_lvl      = fire_ring_level;
        res.fire_ring = ring_lvl;
      end else if (rq.interlock_closed) begin
        ring_lvl       = rdy_ring_level;
        res.ready_ring = ring_lvl;
      end
    end
    return res;
  endfunction

  function automatic in_req_t make_req(logic [31:0] now, logic [5:0] flags);
    in_req_t rq;
    rq.now_ms           = now;
    rq.fire_enable      = flags[0];
    rq.firing_now       = flags[1];
    rq.charging         = flags[2];
    rq.interlock_closed = flags[3];
    rq.fault            = flags[4];
    rq.critical_battery = flags[5];
    return rq;
  endfunction

  function automatic dir_row_t dir_row(logic [31:0] now, logic [5:0] flags, bit chk,
                                       out_res_t res);
    dir_row_t r;
    r.rq  = make_req(now, flags);
    r.chk = chk;
    r.res = res;
    return r;
  endfunction

  // One register write per clock edge; the caller lowers the enable after
  // the last one so that it stays high across a burst of writes.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_ERROR_PERIOD: err_period      = val;
      CFG_RAMP_STEP:    ramp_step       = val[7:0];
      CFG_ERROR_LEVEL:  err_level       = val[6:0];
      CFG_CHARGE_LEVEL: chg_level       = val[6:0];
      CFG_READY_LEVEL:  rdy_level       = val[6:0];
      CFG_READY_RING:   rdy_ring_level  = val[6:0];
      CFG_FIRE_RING:    fire_ring_level = val[6:0];
      default: ;
    endcase
  endtask

  // Presents one request, holds it until accepted and records what should
  // come back. Returns at the edge where the request was taken.
  task automatic send_item(input in_req_t rq, input bit chk, input out_res_t res);
    out_res_t pred;
    if (!calm && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= rq;
    do @(posedge clk_i); while (in_stall_o);
    // The predictor runs on every request so that its state stays in step,
    // even when the expected levels are typed into the table.
    pred = predict_levels(rq);
    expected_levels_q.push_back(chk ? res : pred);
  endtask

  // Drops valid, waits until every result is in, then waits out the settle time.
  task automatic wait_drained(input int unsigned settle);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_levels_q.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  // Result side: random stall, except during the calm stretch.
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < IdlePct);
  end

  // Result checker. Every result taken is compared against the oldest
  // outstanding prediction; a result with nothing outstanding is an error.
  always @(posedge clk_i) begin
    out_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_levels_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("unexpected result r=%0d g=%0d b=%0d rr=%0d fr=%0d",
                   out_res_o.red_level, out_res_o.green_level, out_res_o.blue_level,
                   out_res_o.ready_ring, out_res_o.fire_ring);
        end
      end else begin
        want = expected_levels_q.pop_front();
        if (out_res_o.red_level !== want.red_level ||
            out_res_o.green_level !== want.green_level ||
            out_res_o.blue_level !== want.blue_level ||
            out_res_o.ready_ring !== want.ready_ring ||
            out_res_o.fire_ring !== want.fire_ring) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("level mismatch: exp r=%0d g=%0d b=%0d rr=%0d fr=%0d",
                     want.red_level, want.green_level, want.blue_level,
                     want.ready_ring, want.fire_ring);
            $display("                got r=%0d g=%0d b=%0d rr=%0d fr=%0d",
                     out_res_o.red_level, out_res_o.green_level, out_res_o.blue_level,
                     out_res_o.ready_ring, out_res_o.fire_ring);
          end
        end
      end
    end
  end

  // Main sequence: reset, directed table at the reset configuration, then
  // phases of random ticks, each phase under its own register settings.
  initial begin : stim
    dir_row_t    dir_tab[$];
    logic [15:0] cfg_vals[7];
    logic [5:0]  cur_flags;
    logic [31:0] cur_now;
    int unsigned pick;

    err_period      = ErrorPeriodRst;
    ramp_step       = RampStepRst;
    err_level       = ErrorLevelRst;
    chg_level       = ChargeLevelRst;
    rdy_level       = ReadyLevelRst;
    rdy_ring_level  = ReadyRingRst;
    fire_ring_level = FireRingRst;
    flag_copy       = '0;
    mark            = '0;
    main_lvl        = '0;
    ring_lvl        = '0;
    ramp_dn         = 1'b0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Steady states of the priority chain, with levels typed in where they
    // follow directly from the reset register values.
    dir_tab.push_back(dir_row(32'd0, '0, 1'b1,
                              {7'd0, 7'd0, ChargeLevelRst, 7'd0, 7'd0}));
    dir_tab.push_back(dir_row(32'd1, FlagIlk, 1'b1,
                              {7'd0, ReadyLevelRst, 7'd0, 7'd0, 7'd0}));
    dir_tab.push_back(dir_row(32'd2, FlagIlk | FlagEn, 1'b1,
                              {7'd0, 7'd0, 7'd0, ReadyRingRst, 7'd0}));
    dir_tab.push_back(dir_row(32'd3, FlagIlk | FlagEn | FlagFire, 1'b1,
                              {7'd0, 7'd0, 7'd0, 7'd0, FireRingRst}));
    // Critical battery with the interlock closed goes dark; the ring stays.
    dir_tab.push_back(dir_row(32'd4, FlagBat | FlagIlk | FlagEn, 1'b1,
                              {7'd0, 7'd0, 7'd0, ReadyRingRst, 7'd0}));
    // Critical battery with the interlock open is not dark.
    dir_tab.push_back(dir_row(32'd5, FlagBat | FlagEn, 1'b1,
                              {7'd0, 7'd0, ChargeLevelRst, 7'd0, 7'd0}));
    // Fault blink: start, within the period, past it, clock behind the mark,
    // then a mark taken at time zero which counts as unset on the next tick.
    dir_tab.push_back(dir_row(32'd1000, FlagFlt | FlagIlk | FlagEn, 1'b0, '0));
    dir_tab.push_back(dir_row(32'd1200, FlagFlt | FlagIlk | FlagEn, 1'b0, '0));
    dir_tab.push_back(dir_row(32'd1501, FlagFlt | FlagIlk | FlagEn, 1'b0, '0));
    dir_tab.push_back(dir_row(32'd1400, FlagFlt | FlagIlk | FlagEn, 1'b0, '0));
    dir_tab.push_back(dir_row(32'd0, FlagFlt | FlagIlk | FlagEn, 1'b0, '0));
    dir_tab.push_back(dir_row(32'd1, FlagFlt | FlagIlk | FlagEn, 1'b0, '0));
    // Breathing: start at the top, no step yet, one step, catch-up, clock
    // behind the mark, then huge gaps that saturate at both ends.
    dir_tab.push_back(dir_row(32'd2000, FlagChg | FlagIlk, 1'b0, '0));
    dir_tab.push_back(dir_row(32'd2005, FlagChg | FlagIlk, 1'b0, '0));
    dir_tab.push_back(dir_row(32'd2013, FlagChg | FlagIlk, 1'b0, '0));
    dir_tab.push_back(dir_row(32'd2100, FlagChg | FlagIlk, 1'b0, '0));
    dir_tab.push_back(dir_row(32'd1900, FlagChg | FlagIlk, 1'b0, '0));
    dir_tab.push_back(dir_row(32'd2000000, FlagChg | FlagIlk, 1'b0, '0));
    dir_tab.push_back(dir_row(32'd4000000, FlagChg | FlagIlk, 1'b0, '0));
    // Largest clock value; charging overrides critical battery.
    dir_tab.push_back(dir_row(32'hFFFF_FFFF, FlagChg | FlagBat | FlagIlk, 1'b0, '0));
    dir_tab.push_back(dir_row(32'hFFFF_FFFF,
                              FlagChg | FlagBat | FlagIlk | FlagEn | FlagFire, 1'b0, '0));
    dir_tab.push_back(dir_row(32'hFFFF_FFFF, 6'h3F, 1'b0, '0));
    // Firing without enable lights no ring, with a dark main LED; with enable it lights the fire ring.
    dir_tab.push_back(dir_row(32'h7FFF_FFFF, FlagBat | FlagIlk | FlagFire, 1'b1, '0));
    dir_tab.push_back(dir_row(32'h8000_0000, FlagEn | FlagFire, 1'b1,
                              {7'd0, 7'd0, ChargeLevelRst, 7'd0, FireRingRst}));

    foreach (dir_tab[i]) send_item(dir_tab[i].rq, dir_tab[i].chk, dir_tab[i].res);

    cur_flags = '0;
    cur_now   = 32'd5000;
    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      if (phase != 0) begin
        // Registers only change with nothing in flight.
        wait_drained(4);
        case (phase)
          1: cfg_vals = '{16'd1, 16'd1, 16'd127, 16'd1, 16'd0, 16'd0, 16'd0};
          2: cfg_vals = '{16'd65535, 16'd255, 16'd127, 16'd127, 16'd127, 16'd127, 16'd127};
          // Zero ramp step, zero charge level and a dark blink level.
          3: cfg_vals = '{16'd3, 16'd0, 16'd0, 16'd0, 16'd5, 16'd1, 16'd2};
          4, 6: begin
            cfg_vals[0] = 16'($urandom_range(1, 2000));
            cfg_vals[1] = 16'($urandom_range(1, 40));
            for (int k = 2; k < 7; k++) cfg_vals[k] = 16'($urandom_range(0, 127));
          end
          // Raw 16-bit data, so the upper bits must be dropped by the block.
          default: for (int k = 0; k < 7; k++) cfg_vals[k] = 16'($urandom_range(0, 65535));
        endcase
        for (int k = 0; k < 7; k++) write_reg(CfgIdxW'(k), cfg_vals[k]);
        if (phase >= 4) write_reg(CfgUnusedIdx, 16'($urandom_range(0, 65535)));
        @(posedge clk_i);
        cfg_we_i <= 1'b0;
      end
      calm <= (phase == 1);

      for (int unsigned n = 0; n < ItemsPerPhase; n++) begin
        // Flags mostly hold for long stretches so that blink and breathe get
        // well past their first tick; now and then they jump or one flips.
        pick = $urandom_range(0, 99);
        if (pick < 8) cur_flags = 6'($urandom_range(0, 63));
        else if (pick < 12) cur_flags = cur_flags ^ (6'd1 << $urandom_range(0, 5));

        pick = $urandom_range(0, 99);
        if (pick < 55) cur_now = cur_now + $urandom_range(0, 40);
        else if (pick < 75) cur_now = cur_now + $urandom_range(0, 1500);
        else if (pick < 85) cur_now = cur_now + $urandom_range(0, 300000);
        else if (pick < 92) cur_now = cur_now - $urandom_range(1, 700);
        else if (pick < 96) cur_now = $urandom();
        else if (pick < 98) cur_now = 32'hFFFF_FFFF - $urandom_range(0, 50);
        else cur_now = '0;

        // Hold the sender once mid-run until the result side has caught up.
        if (phase == 4 && n == 50) wait_drained(4);
        send_item(make_req(cur_now, cur_flags), 1'b0, '0);
      end
    end

    wait_drained(40);
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
